/* rtl/csl_pkg.sv */
package csl_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_PUNCT, M_LINE, M_BLOCK, M_BSTAR,
    M_STR, M_ESC, M_OCT, M_HEX1, M_HEX, M_DONE
  } mode_t;

  localparam logic [2:0] K_NUM   = 3'd0;
  localparam logic [2:0] K_IDENT = 3'd1;
  localparam logic [2:0] K_KW    = 3'd2;
  localparam logic [2:0] K_PUNCT = 3'd3;
  localparam logic [2:0] K_STR   = 3'd4;
  localparam logic [2:0] K_SBYTE = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;
  localparam logic [2:0] K_ERR   = 3'd7;

  localparam logic [63:0] E_BLOCK = 64'd1;
  localparam logic [63:0] E_STR   = 64'd2;
  localparam logic [63:0] E_HEX   = 64'd3;
  localparam logic [63:0] E_CHAR  = 64'd4;
  localparam logic [63:0] E_LONG  = 64'd5;

  localparam logic [7:0] ESC_CHAR = 8'd27;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [63:0] value;
  } token_t;

  // one transaction's worth of results from one source byte
  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || c == 8'd95;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    if (is_digit(c)) r = c - 8'd48;
    else if (c >= 8'd97) r = c - 8'd87;
    else r = c - 8'd55;
    return r[3:0];
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'd97:  r = 8'd7;
      8'd98:  r = 8'd8;
      8'd116: r = 8'd9;
      8'd110: r = 8'd10;
      8'd102: r = 8'd12;
      8'd114: r = 8'd13;
      8'd118: r = 8'd11;
      8'd101: r = ESC_CHAR;
      default: r = c;
    endcase
    return r;
  endfunction

  // keyword index lookup; bit 3 set when matched
  function automatic logic [3:0] kw_lookup(input logic [47:0] w, input logic [15:0] len);
    logic [3:0] r;
    r = 4'd0;
    if (len == 16'd6 && w == 48'h72_65_74_75_72_6e) r = 4'd8;
    if (len == 16'd2 && w == 48'h69_66)             r = 4'd9;
    if (len == 16'd4 && w == 48'h65_6c_73_65)       r = 4'd10;
    if (len == 16'd5 && w == 48'h77_68_69_6c_65)    r = 4'd11;
    if (len == 16'd3 && w == 48'h66_6f_72)          r = 4'd12;
    if (len == 16'd3 && w == 48'h69_6e_74)          r = 4'd13;
    if (len == 16'd4 && w == 48'h63_68_61_72)       r = 4'd14;
    if (len == 16'd6 && w == 48'h73_69_7a_65_6f_66) r = 4'd15;
    return r;
  endfunction

endpackage

/* rtl/csl_if.sv */
interface csl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface csl_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_offset;
  logic [15:0] token_length;
  logic [63:0] token_value;
  logic        last_of_run;
  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output token_value, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input token_value, input last_of_run,
                output ready);
endinterface

/* rtl/csl_front.sv */
module csl_front #(
  parameter int PosW = 17,
  parameter logic [PosW-1:0] MaxBytes = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  output logic          q_push,
  output csl_pkg::pair_t q_data,
  input  logic          q_full
);

  csl_pkg::mode_t mode, mode_next;
  logic [15:0] start_offset, start_offset_next;
  logic [15:0] run_length, run_length_next;
  logic [PosW-1:0] byte_position;
  logic [63:0] number_accumulator, number_accumulator_next;
  logic [47:0] keyword_window, keyword_window_next;
  logic [7:0] escape_accumulator, escape_accumulator_next;
  logic [1:0] escape_digit_count, escape_digit_count_next;
  logic [15:0] decoded_count, decoded_count_next;
  logic [7:0] held_character, held_character_next;
  logic error_latched, error_next;

  logic [1:0] n;
  csl_pkg::token_t tk [2];
  logic [15:0] pos16;
  logic accept;
  logic [67:0] acc_wide;
  logic [3:0] kw;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign pos16 = byte_position[15:0];
  // ten times the accumulator plus the new digit, with room to see overflow
  assign acc_wide = ({4'd0, number_accumulator} << 3) + ({4'd0, number_accumulator} << 1) +
                    {60'd0, in_byte - 8'd48};
  assign kw = csl_pkg::kw_lookup(keyword_window, run_length);

  always_comb begin
    logic [7:0] c;
    logic again;
    logic [63:0] d;
    c = in_byte;
    mode_next = mode;
    start_offset_next = start_offset;
    run_length_next = run_length;
    number_accumulator_next = number_accumulator;
    keyword_window_next = keyword_window;
    escape_accumulator_next = escape_accumulator;
    escape_digit_count_next = escape_digit_count;
    decoded_count_next = decoded_count;
    held_character_next = held_character;
    error_next = error_latched;
    n = 2'd0;
    tk[0] = '0;
    tk[1] = '0;
    again = 1'b0;
    d = {56'd0, c - 8'd48};

    if (mode == csl_pkg::M_DONE || error_latched) begin
      n = 2'd0;
    end else if (c != 8'd0 && byte_position >= MaxBytes) begin
      tk[0] = '{csl_pkg::K_ERR, pos16, 16'd0, csl_pkg::E_LONG};
      n = 2'd1;
      error_next = 1'b1;
      mode_next = csl_pkg::M_DONE;
    end else begin
      // first pass: modes that may hand the byte back to idle
      case (mode)
        csl_pkg::M_NUM: begin
          if (csl_pkg::is_digit(c)) begin
            number_accumulator_next = (acc_wide[67:64] != 4'd0) ?
                                      64'hFFFF_FFFF_FFFF_FFFF : acc_wide[63:0];
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
          end else begin
            tk[0] = '{csl_pkg::K_NUM, start_offset, run_length, number_accumulator};
            n = 2'd1;
            again = 1'b1;
          end
        end
        csl_pkg::M_IDENT: begin
          if (csl_pkg::is_alpha(c) || csl_pkg::is_digit(c)) begin
            keyword_window_next = {keyword_window[39:0], c};
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
          end else begin
            if (kw[3])
              tk[0] = '{csl_pkg::K_KW, start_offset, run_length, {61'd0, kw[2:0]}};
            else
              tk[0] = '{csl_pkg::K_IDENT, start_offset, run_length, 64'd0};
            n = 2'd1;
            again = 1'b1;
          end
        end
        csl_pkg::M_PUNCT: begin
          if (held_character == 8'd47 && c == 8'd47) mode_next = csl_pkg::M_LINE;
          else if (held_character == 8'd47 && c == 8'd42) mode_next = csl_pkg::M_BLOCK;
          else if (held_character != 8'd47 && c == 8'd61) begin
            tk[0] = '{csl_pkg::K_PUNCT, start_offset, 16'd2,
                      {48'd0, 8'd61, held_character}};
            n = 2'd1;
            mode_next = csl_pkg::M_IDLE;
          end else begin
            tk[0] = '{csl_pkg::K_PUNCT, start_offset, 16'd1, {56'd0, held_character}};
            n = 2'd1;
            again = 1'b1;
          end
        end
        csl_pkg::M_LINE: begin
          if (c == 8'd0) again = 1'b1;
          else if (c == 8'd10) mode_next = csl_pkg::M_IDLE;
        end
        csl_pkg::M_BLOCK, csl_pkg::M_BSTAR: begin
          if (c == 8'd0) begin
            tk[0] = '{csl_pkg::K_ERR, start_offset, 16'd0, csl_pkg::E_BLOCK};
            n = 2'd1;
            error_next = 1'b1;
            mode_next = csl_pkg::M_DONE;
          end else if (c == 8'd42) mode_next = csl_pkg::M_BSTAR;
          else if (c == 8'd47 && mode == csl_pkg::M_BSTAR) mode_next = csl_pkg::M_IDLE;
          else mode_next = csl_pkg::M_BLOCK;
        end
        csl_pkg::M_STR: begin
          if (c == 8'd0 || c == 8'd10) begin
            tk[0] = '{csl_pkg::K_ERR, start_offset, 16'd0, csl_pkg::E_STR};
            n = 2'd1;
            error_next = 1'b1;
            mode_next = csl_pkg::M_DONE;
          end else begin
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
            if (c == 8'd34) begin
              tk[0] = '{csl_pkg::K_STR, start_offset, run_length_next,
                        {48'd0, decoded_count}};
              n = 2'd1;
              mode_next = csl_pkg::M_IDLE;
            end else if (c == 8'd92) mode_next = csl_pkg::M_ESC;
            else begin
              tk[0] = '{csl_pkg::K_SBYTE, start_offset, 16'd0, {56'd0, c}};
              n = 2'd1;
              if (decoded_count != 16'hFFFF) decoded_count_next = decoded_count + 16'd1;
            end
          end
        end
        csl_pkg::M_ESC: begin
          if (c == 8'd0) begin
            tk[0] = '{csl_pkg::K_ERR, start_offset, 16'd0, csl_pkg::E_STR};
            n = 2'd1;
            error_next = 1'b1;
            mode_next = csl_pkg::M_DONE;
          end else begin
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
            if (c >= 8'd48 && c <= 8'd55) begin
              escape_accumulator_next = c - 8'd48;
              escape_digit_count_next = 2'd1;
              mode_next = csl_pkg::M_OCT;
            end else if (c == 8'd120) begin
              escape_accumulator_next = 8'd0;
              mode_next = csl_pkg::M_HEX1;
            end else begin
              tk[0] = '{csl_pkg::K_SBYTE, start_offset, 16'd0,
                        {56'd0, csl_pkg::esc_map(c)}};
              n = 2'd1;
              if (decoded_count != 16'hFFFF) decoded_count_next = decoded_count + 16'd1;
              mode_next = csl_pkg::M_STR;
            end
          end
        end
        csl_pkg::M_OCT: begin
          if (c >= 8'd48 && c <= 8'd55 && escape_digit_count != 2'd3) begin
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
            escape_accumulator_next = {escape_accumulator[4:0], 3'd0} + (c - 8'd48);
            escape_digit_count_next = escape_digit_count + 2'd1;
            if (escape_digit_count == 2'd2) begin
              tk[0] = '{csl_pkg::K_SBYTE, start_offset, 16'd0,
                        {56'd0, escape_accumulator_next}};
              n = 2'd1;
              if (decoded_count != 16'hFFFF) decoded_count_next = decoded_count + 16'd1;
              mode_next = csl_pkg::M_STR;
            end
          end else begin
            tk[0] = '{csl_pkg::K_SBYTE, start_offset, 16'd0, {56'd0, escape_accumulator}};
            n = 2'd1;
            if (decoded_count != 16'hFFFF) decoded_count_next = decoded_count + 16'd1;
            mode_next = csl_pkg::M_STR;
            again = 1'b1;
          end
        end
        csl_pkg::M_HEX1: begin
          if (!csl_pkg::is_hex(c)) begin
            tk[0] = '{csl_pkg::K_ERR, start_offset, 16'd0, csl_pkg::E_HEX};
            n = 2'd1;
            error_next = 1'b1;
            mode_next = csl_pkg::M_DONE;
          end else begin
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
            escape_accumulator_next = {4'd0, csl_pkg::hex_val(c)};
            mode_next = csl_pkg::M_HEX;
          end
        end
        csl_pkg::M_HEX: begin
          if (csl_pkg::is_hex(c)) begin
            if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
            escape_accumulator_next = {escape_accumulator[3:0], csl_pkg::hex_val(c)};
          end else begin
            tk[0] = '{csl_pkg::K_SBYTE, start_offset, 16'd0, {56'd0, escape_accumulator}};
            n = 2'd1;
            if (decoded_count != 16'hFFFF) decoded_count_next = decoded_count + 16'd1;
            mode_next = csl_pkg::M_STR;
            again = 1'b1;
          end
        end
        default: again = (mode == csl_pkg::M_IDLE);
      endcase

      // string modes re-entered hand back to the string mode, whose work
      // a second pass repeats; only the idle re-entry starts a token
      if (again && (mode == csl_pkg::M_OCT || mode == csl_pkg::M_HEX)) begin
        if (c == 8'd0 || c == 8'd10) begin
          tk[1] = '{csl_pkg::K_ERR, start_offset, 16'd0, csl_pkg::E_STR};
          n = 2'd2;
          error_next = 1'b1;
          mode_next = csl_pkg::M_DONE;
        end else begin
          if (run_length != 16'hFFFF) run_length_next = run_length + 16'd1;
          if (c == 8'd34) begin
            tk[1] = '{csl_pkg::K_STR, start_offset, run_length_next,
                      {48'd0, decoded_count_next}};
            n = 2'd2;
            mode_next = csl_pkg::M_IDLE;
          end else if (c == 8'd92) mode_next = csl_pkg::M_ESC;
          else begin
            tk[1] = '{csl_pkg::K_SBYTE, start_offset, 16'd0, {56'd0, c}};
            n = 2'd2;
            if (decoded_count_next != 16'hFFFF)
              decoded_count_next = decoded_count_next + 16'd1;
          end
        end
      end else if (again) begin
        mode_next = csl_pkg::M_IDLE;
        start_offset_next = pos16;
        run_length_next = 16'd1;
        if (c == 8'd0) begin
          tk[n[0]] = '{csl_pkg::K_END, pos16, 16'd0, 64'd0};
          n = n + 2'd1;
          mode_next = csl_pkg::M_DONE;
        end else if (csl_pkg::is_space(c)) run_length_next = 16'd0;
        else if (csl_pkg::is_digit(c)) begin
          number_accumulator_next = d;
          mode_next = csl_pkg::M_NUM;
        end else if (c == 8'd34) begin
          decoded_count_next = 16'd0;
          mode_next = csl_pkg::M_STR;
        end else if (csl_pkg::is_alpha(c)) begin
          keyword_window_next = {40'd0, c};
          mode_next = csl_pkg::M_IDENT;
        end else if (c == 8'd47 || c == 8'd61 || c == 8'd33 || c == 8'd60 ||
                     c == 8'd62) begin
          held_character_next = c;
          mode_next = csl_pkg::M_PUNCT;
        end else if (csl_pkg::is_punct(c)) begin
          tk[n[0]] = '{csl_pkg::K_PUNCT, pos16, 16'd1, {56'd0, c}};
          n = n + 2'd1;
        end else begin
          tk[n[0]] = '{csl_pkg::K_ERR, pos16, 16'd0, csl_pkg::E_CHAR};
          n = n + 2'd1;
          error_next = 1'b1;
          mode_next = csl_pkg::M_DONE;
        end
      end
    end
  end

  assign q_push = accept && n != 2'd0;
  assign q_data = '{two: n[1], t0: tk[0], t1: tk[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csl_pkg::M_IDLE;
      start_offset <= '0;
      run_length <= '0;
      byte_position <= '0;
      number_accumulator <= '0;
      keyword_window <= '0;
      escape_accumulator <= '0;
      escape_digit_count <= '0;
      decoded_count <= '0;
      held_character <= '0;
      error_latched <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      start_offset <= start_offset_next;
      run_length <= run_length_next;
      number_accumulator <= number_accumulator_next;
      keyword_window <= keyword_window_next;
      escape_accumulator <= escape_accumulator_next;
      escape_digit_count <= escape_digit_count_next;
      decoded_count <= decoded_count_next;
      held_character <= held_character_next;
      error_latched <= error_next;
      if (mode != csl_pkg::M_DONE && !error_latched &&
          !(in_byte != 8'd0 && byte_position >= MaxBytes) && byte_position < MaxBytes)
        byte_position <= byte_position + 1'b1;
    end
  end

endmodule

/* rtl/csl_back.sv */
module csl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_push,
  input  csl_pkg::pair_t q_data,
  output logic           q_full,
  output logic           out_valid,
  input  logic           out_ready,
  output csl_pkg::token_t out_tok,
  output logic           out_last
);

  // two-entry queue of result pairs
  csl_pkg::pair_t slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic sub;
  logic pop;
  csl_pkg::pair_t head;

  assign head = slot[rd_ptr];
  assign q_full = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign out_tok = sub ? head.t1 : head.t0;
  assign out_last = sub || !head.two;
  assign pop = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (q_push) slot[wr_ptr] <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
      sub <= 1'b0;
    end else begin
      if (q_push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, q_push} - {1'b0, pop};
      if (out_valid && out_ready) sub <= !out_last;
    end
  end

endmodule

/* rtl/c_subset_lexer.sv */
// results: a token enters the result queue when the byte that ends it is taken
// throughput: one source byte per cycle while the result queue has room; a byte
// with two results holds the queue head until both are taken, and the input
// waits whenever the two-entry result queue fills behind it
// reset: synchronous, active high; lexer returns to idle at offset zero,
// queue empties, latched error clears
module c_subset_lexer #(
  parameter int MAX_SOURCE_BYTES = 65536
) (
  input logic clk,
  input logic rst,
  csl_byte_if.sink    in_ch,
  csl_token_if.source out_ch
);

  // position counter wide enough to hold the limit itself
  localparam int PosW = $clog2(MAX_SOURCE_BYTES + 1);

  logic           q_push;
  csl_pkg::pair_t q_data;
  logic           q_full;
  csl_pkg::token_t tok;

  // front: mode machine, one source byte per transaction
  csl_front #(
    .PosW(PosW),
    .MaxBytes(PosW'(MAX_SOURCE_BYTES))
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_byte(in_ch.source_byte), .in_ready(in_ch.ready),
    .q_push(q_push), .q_data(q_data), .q_full(q_full)
  );

  // back: queue and serialiser of one or two results per byte
  csl_back u_back (
    .clk(clk), .rst(rst),
    .q_push(q_push), .q_data(q_data), .q_full(q_full),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_tok(tok), .out_last(out_ch.last_of_run)
  );

  assign out_ch.token_kind   = tok.kind;
  assign out_ch.token_offset = tok.offset;
  assign out_ch.token_length = tok.length;
  assign out_ch.token_value  = tok.value;

`ifndef NO_ASSERTIONS
  // input is refused only while the result queue is full
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid) else $error("stall with empty output");
  // a string byte never carries a length
  a_sbyte: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.token_kind == csl_pkg::K_SBYTE) |-> out_ch.token_length == 16'd0)
    else $error("string byte with length");
  // the end token closes its byte's run
  a_end: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.token_kind == csl_pkg::K_END) |-> out_ch.last_of_run)
    else $error("end token not last");
`endif

endmodule

/* tb/tb_c_subset_lexer.sv */
`timescale 1ns / 1ps

module tb_c_subset_lexer;

  localparam int SRC_LIMIT   = 2048;       // source limit given to the block
  localparam int CYCLE_LIMIT = 4_000_000;  // covers the full-length overflow source too
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  csl_byte_if  in_ch ();
  csl_token_if out_ch ();

  c_subset_lexer #(
    .MAX_SOURCE_BYTES (SRC_LIMIT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // one expected token together with its end-of-run flag
  typedef struct {
    csl_pkg::token_t tok;
    logic   last;
  } token_exp_t;

  token_exp_t token_fifo[$];   // tokens still owed by the block
  token_exp_t step_toks[$];    // tokens caused by the byte being lexed

  // shadow lexer state
  csl_pkg::mode_t lx_mode;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  int          src_pos;
  logic [63:0] num_acc;
  logic [47:0] kw_win;
  logic [7:0]  esc_acc;
  int          esc_digits;
  logic [15:0] str_count;
  logic [7:0]  held;
  bit          err_latched;

  int  errors;
  int  cycles;
  int  bytes_sent;
  int  tokens_seen;
  bit  quiet;      // no idling on either side while set
  bit  hold_req;   // asks the receiver for one long hold-off
  int  end_choice;
  logic [7:0] frag[$];

  string kw_names[8] = '{"return", "if", "else", "while", "for", "int", "char", "sizeof"};

  // clock and cycle count
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // character classes, written afresh for the predictor
  // ---------------------------------------------------------------------------
  function automatic bit dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit octd(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic bit alph(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit spc(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit pun(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // -1 when not a hex digit
  function automatic int hexd(input logic [7:0] c);
    if (dig(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // ---------------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------------
  function automatic void emit(input logic [2:0] k, input logic [15:0] off,
                               input logic [15:0] len, input logic [63:0] val);
    token_exp_t e;
    if (step_toks.size() >= 2) return;
    e.tok.kind   = k;
    e.tok.offset = off;
    e.tok.length = len;
    e.tok.value  = val;
    e.last       = 1'b0;
    step_toks.push_back(e);
  endfunction

  function automatic void lex_fail(input logic [15:0] off, input logic [63:0] code);
    emit(csl_pkg::K_ERR, off, 16'd0, code);
    err_latched = 1'b1;
    lx_mode = csl_pkg::M_DONE;
  endfunction

  function automatic void bump();
    if (tok_len != 16'hFFFF) tok_len++;
  endfunction

  function automatic void str_byte(input logic [7:0] b);
    emit(csl_pkg::K_SBYTE, tok_start, 16'd0, {56'd0, b});
    if (str_count != 16'hFFFF) str_count++;
  endfunction

  // keyword only when the whole identifier fits the window and matches
  function automatic void close_ident();
    logic [47:0] w;
    if (tok_len <= 16'd6) begin
      for (int k = 0; k < 8; k++) begin
        w = '0;
        for (int i = 0; i < kw_names[k].len(); i++) w = {w[39:0], kw_names[k][i]};
        if (kw_names[k].len() == tok_len && w == kw_win) begin
          emit(csl_pkg::K_KW, tok_start, tok_len, 64'(k));
          return;
        end
      end
    end
    emit(csl_pkg::K_IDENT, tok_start, tok_len, 64'd0);
  endfunction

  function automatic void open_token(input logic [7:0] c, input logic [15:0] p);
    tok_start = p;
    tok_len   = 16'd1;
    if (c == 8'd0) begin
      emit(csl_pkg::K_END, p, 16'd0, 64'd0);
      lx_mode = csl_pkg::M_DONE;
    end else if (spc(c)) begin
      tok_len = 16'd0;
    end else if (dig(c)) begin
      num_acc = 64'(c - "0");
      lx_mode = csl_pkg::M_NUM;
    end else if (c == "\"") begin
      str_count = 16'd0;
      lx_mode = csl_pkg::M_STR;
    end else if (alph(c)) begin
      kw_win = 48'(c);
      lx_mode = csl_pkg::M_IDENT;
    end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
      held = c;
      lx_mode = csl_pkg::M_PUNCT;
    end else if (pun(c)) begin
      emit(csl_pkg::K_PUNCT, p, 16'd1, 64'(c));
    end else begin
      lex_fail(p, csl_pkg::E_CHAR);
    end
  endfunction

  // returns 1 when the byte has to be looked at again in the new mode
  function automatic bit lex_byte(input logic [7:0] c, input logic [15:0] p);
    int h;
    logic [63:0] d;
    logic [7:0] m;
    case (lx_mode)
      csl_pkg::M_IDLE: begin
        open_token(c, p);
        return 1'b0;
      end
      csl_pkg::M_NUM: begin
        if (dig(c)) begin
          d = 64'(c - "0");
          if (num_acc > ({64{1'b1}} - d) / 64'd10) num_acc = {64{1'b1}};
          else num_acc = num_acc * 64'd10 + d;
          bump();
          return 1'b0;
        end
        emit(csl_pkg::K_NUM, tok_start, tok_len, num_acc);
        lx_mode = csl_pkg::M_IDLE;
        return 1'b1;
      end
      csl_pkg::M_IDENT: begin
        if (alph(c) || dig(c)) begin
          kw_win = {kw_win[39:0], c};
          bump();
          return 1'b0;
        end
        close_ident();
        lx_mode = csl_pkg::M_IDLE;
        return 1'b1;
      end
      csl_pkg::M_PUNCT: begin
        if (held == "/") begin
          if (c == "/") begin
            lx_mode = csl_pkg::M_LINE;
            return 1'b0;
          end
          if (c == "*") begin
            lx_mode = csl_pkg::M_BLOCK;
            return 1'b0;
          end
        end else if (c == "=") begin
          emit(csl_pkg::K_PUNCT, tok_start, 16'd2, {48'd0, 8'h3d, held});
          lx_mode = csl_pkg::M_IDLE;
          return 1'b0;
        end
        emit(csl_pkg::K_PUNCT, tok_start, 16'd1, 64'(held));
        lx_mode = csl_pkg::M_IDLE;
        return 1'b1;
      end
      csl_pkg::M_LINE: begin
        if (c == 8'd0) begin
          lx_mode = csl_pkg::M_IDLE;
          return 1'b1;
        end
        if (c == 8'd10) lx_mode = csl_pkg::M_IDLE;
        return 1'b0;
      end
      csl_pkg::M_BLOCK, csl_pkg::M_BSTAR: begin
        if (c == 8'd0) lex_fail(tok_start, csl_pkg::E_BLOCK);
        else if (c == "*") lx_mode = csl_pkg::M_BSTAR;
        else if (c == "/" && lx_mode == csl_pkg::M_BSTAR) lx_mode = csl_pkg::M_IDLE;
        else lx_mode = csl_pkg::M_BLOCK;
        return 1'b0;
      end
      csl_pkg::M_STR: begin
        if (c == 8'd0 || c == 8'd10) begin
          lex_fail(tok_start, csl_pkg::E_STR);
          return 1'b0;
        end
        bump();
        if (c == "\"") begin
          emit(csl_pkg::K_STR, tok_start, tok_len, 64'(str_count));
          lx_mode = csl_pkg::M_IDLE;
        end else if (c == "\\") begin
          lx_mode = csl_pkg::M_ESC;
        end else begin
          str_byte(c);
        end
        return 1'b0;
      end
      csl_pkg::M_ESC: begin
        if (c == 8'd0) begin
          lex_fail(tok_start, csl_pkg::E_STR);
          return 1'b0;
        end
        bump();
        if (octd(c)) begin
          esc_acc = c - "0";
          esc_digits = 1;
          lx_mode = csl_pkg::M_OCT;
          return 1'b0;
        end
        if (c == "x") begin
          esc_acc = 8'd0;
          lx_mode = csl_pkg::M_HEX1;
          return 1'b0;
        end
        case (c)
          "a": m = 8'd7;
          "b": m = 8'd8;
          "t": m = 8'd9;
          "n": m = 8'd10;
          "f": m = 8'd12;
          "r": m = 8'd13;
          "v": m = 8'd11;
          "e": m = 8'd27;
          default: m = c;
        endcase
        str_byte(m);
        lx_mode = csl_pkg::M_STR;
        return 1'b0;
      end
      csl_pkg::M_OCT: begin
        if (octd(c) && esc_digits < 3) begin
          bump();
          esc_acc = {esc_acc[4:0], 3'b000} + (c - "0");
          esc_digits++;
          if (esc_digits >= 3) begin
            str_byte(esc_acc);
            lx_mode = csl_pkg::M_STR;
          end
          return 1'b0;
        end
        str_byte(esc_acc);
        lx_mode = csl_pkg::M_STR;
        return 1'b1;
      end
      csl_pkg::M_HEX1: begin
        h = hexd(c);
        if (h < 0) begin
          lex_fail(tok_start, csl_pkg::E_HEX);
          return 1'b0;
        end
        bump();
        esc_acc = 8'(h);
        lx_mode = csl_pkg::M_HEX;
        return 1'b0;
      end
      csl_pkg::M_HEX: begin
        h = hexd(c);
        if (h >= 0) begin
          bump();
          esc_acc = {esc_acc[3:0], 4'(h)};
          return 1'b0;
        end
        str_byte(esc_acc);
        lx_mode = csl_pkg::M_STR;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // works out the tokens owed for one accepted source byte
  function automatic void predict_tokens(input logic [7:0] c);
    step_toks.delete();
    if (lx_mode == csl_pkg::M_DONE || err_latched) return;
    if (c != 8'd0 && src_pos >= SRC_LIMIT) begin
      lex_fail(16'(src_pos), csl_pkg::E_LONG);
    end else begin
      if (lex_byte(c, 16'(src_pos))) void'(lex_byte(c, 16'(src_pos)));
      if (src_pos < SRC_LIMIT) src_pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_fifo.push_back(step_toks[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one source byte per transaction
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(b);
    bytes_sent++;
  endtask

  task automatic send_frag();
    foreach (frag[i]) send_byte(frag[i]);
    frag.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request, checks each token
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    token_exp_t e;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        // long hold-off so the result queue fills and the input stalls
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      tokens_seen++;
      if (token_fifo.size() == 0) begin
        errors++;
        $display("%0t: token with none expected: kind %0d offset %0d value %0h",
                 $time, out_ch.token_kind, out_ch.token_offset, out_ch.token_value);
      end else begin
        e = token_fifo.pop_front();
        if (out_ch.token_kind !== e.tok.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, e.tok.kind,
                   out_ch.token_kind);
        end
        if (out_ch.token_offset !== e.tok.offset) begin
          errors++;
          $display("%0t: offset expected %0d actual %0d", $time, e.tok.offset,
                   out_ch.token_offset);
        end
        if (out_ch.token_length !== e.tok.length) begin
          errors++;
          $display("%0t: length expected %0d actual %0d", $time, e.tok.length,
                   out_ch.token_length);
        end
        if (out_ch.token_value !== e.tok.value) begin
          errors++;
          $display("%0t: value expected %0h actual %0h", $time, e.tok.value,
                   out_ch.token_value);
        end
        if (out_ch.last_of_run !== e.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last,
                   out_ch.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random well-formed fragments, always followed by whitespace
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  function automatic void make_fragment();
    int n;
    logic [7:0] b;
    string ops[10] = '{"==", "!=", "<=", ">=", "/=", "=", "!", "<", ">", "/"};
    case ($urandom_range(0, 9))
      0, 1: begin
        // decimal number, now and then long enough to saturate
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 6);
        repeat (n) frag.push_back(8'($urandom_range("0", "9")));
      end
      2, 3: begin
        case ($urandom_range(0, 2))
          0: add_text(kw_names[$urandom_range(0, 7)]);
          1: begin
            // near miss: keyword with something in front or behind
            if ($urandom_range(0, 1)) frag.push_back(pick_alnum());
            add_text(kw_names[$urandom_range(0, 7)]);
            if ($urandom_range(0, 1)) frag.push_back(pick_alnum());
          end
          default: begin
            frag.push_back(8'($urandom_range("a", "z")));
            repeat ($urandom_range(0, 9)) frag.push_back(pick_alnum());
          end
        endcase
      end
      4: begin
        add_text(ops[$urandom_range(0, 9)]);
      end
      5: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          do b = 8'($urandom_range(33, 126));
          while (alph(b) || dig(b) || b == "\"" || b == "/");
          frag.push_back(b);
        end
      end
      6: begin
        add_text("//");
        repeat ($urandom_range(0, 12)) begin
          do b = 8'($urandom_range(1, 255)); while (b == 8'd10);
          frag.push_back(b);
        end
        frag.push_back(8'd10);
      end
      7: begin
        add_text("/*");
        repeat ($urandom_range(0, 12)) begin
          // no slash, so a lone star never closes the comment early
          do b = 8'($urandom_range(1, 255)); while (b == "*" || b == "/");
          frag.push_back(b);
          if ($urandom_range(0, 5) == 0) frag.push_back("*");
        end
        add_text("*/");
      end
      default: begin
        frag.push_back("\"");
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            frag.push_back("\\");
            case ($urandom_range(0, 3))
              0: frag.push_back(8'($urandom_range(1, 255)) | 8'h00);
              1: repeat ($urandom_range(1, 4)) frag.push_back(8'($urandom_range("0", "7")));
              2: begin
                frag.push_back("x");
                repeat ($urandom_range(1, 3)) frag.push_back("3");
              end
              default: frag.push_back("n");
            endcase
            // a raw 0 after the backslash would end the source, and a bare
            // x with no hex digit behind it would stop the lexer
            if (frag[frag.size() - 1] == 8'd0 ||
                (frag[frag.size() - 1] == "x" && frag[frag.size() - 2] == "\\"))
              frag[frag.size() - 1] = "a";
          end else begin
            do b = 8'($urandom_range(1, 255));
            while (b == 8'd10 || b == "\"" || b == "\\");
            frag.push_back(b);
          end
        end
        frag.push_back("\"");
      end
    endcase
    frag.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : " ");
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_keywords_and_numbers();
    add_text("return if else while for int char sizeof areturn x_1 Zz9 sizeofx ");
    add_text("0 18446744073709551615 18446744073709551616 99999999999999999999999\t");
    send_frag();
  endtask

  task automatic test_punctuators();
    add_text("a==b!=c<=d>=e/f/=g=h!i<j>k;(){}[]+-*,.@`~$#:?\\^|%&' ");
    add_text("=!<> / = ");
    send_frag();
  endtask

  task automatic test_comments();
    add_text("// line comment\n/* block ** with * stars */ /**/ /***/x");
    add_text("/*");
    for (int b = 128; b < 256; b++) frag.push_back(8'(b));
    add_text("*/\v\f\r\n");
    send_frag();
  endtask

  task automatic test_strings();
    add_text("\"\" \"ab\\a\\b\\t\\n\\f\\r\\v\\e\\q\\\\\\\"\" ");
    add_text("\"\\0\\101\\1234\\7z\\x41\\xfffG\\xAbc\\\n!\" ");
    frag.push_back("\"");
    for (int b = 128; b < 256; b++) frag.push_back(8'(b));
    add_text("\" ");
    send_frag();
  endtask

  task automatic test_random_source(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 60) == 0) quiet = ~quiet;
      make_fragment();
      send_frag();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    // a burst of single punctuators, each one a token
    repeat (80) frag.push_back(8'($urandom_range(0, 1) ? ";" : ","));
    send_frag();
  endtask

  // the block latches after end or error, so each run closes in one way only
  task automatic test_termination();
    end_choice = $urandom_range(0, 7);
    case (end_choice)
      0: add_text("x");
      1: add_text("// trailing comment");
      2: add_text("/* open comment");
      3: add_text("\"open string\n");
      4: add_text("\"open \\");
      5: add_text("\"bad \\xg\"");
      6: frag.push_back(($urandom_range(0, 1)) ? 8'd1 : 8'($urandom_range(128, 255)));
      default: begin
        // pad to the source limit, then one byte too many
        send_frag();
        quiet = 1'b1;
        while (src_pos < SRC_LIMIT) send_byte(" ");
        quiet = 1'b0;
        frag.push_back("y");
      end
    endcase
    frag.push_back(8'd0);
    // bytes after the end are taken but give nothing
    repeat (5) frag.push_back(8'($urandom_range(0, 255)));
    send_frag();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    tokens_seen = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    lx_mode = csl_pkg::M_IDLE;
    tok_start = '0;
    tok_len = '0;
    src_pos = 0;
    num_acc = '0;
    kw_win = '0;
    esc_acc = '0;
    esc_digits = 0;
    str_count = '0;
    held = '0;
    err_latched = 1'b0;
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.source_byte <= 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keywords_and_numbers();
    test_punctuators();
    test_comments();
    test_strings();
    test_random_source(600);
    test_backpressure();
    test_random_source(600);
    test_termination();
    in_ch.valid <= 1'b0;

    while (token_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("source of %0d bytes lexed, %0d tokens checked, closing case %0d",
             bytes_sent, tokens_seen, end_choice);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/csl_pkg.sv
rtl/csl_if.sv
rtl/csl_front.sv
rtl/csl_back.sv
rtl/c_subset_lexer.sv
tb/tb_c_subset_lexer.sv
